// File: hdl/gs7_pkg.sv
`default_nettype none

package gs7_pkg;

  // Line store depth and the widths that follow from it.
  localparam int unsigned MAX_WIDTH  = 1024;
  localparam int unsigned MAX_HEIGHT = 1024;
  localparam int unsigned MIN_SIZE   = 7;

  localparam int unsigned WIN   = 7;
  localparam int unsigned HALF  = WIN / 2;
  localparam int unsigned LINES = WIN - 1;

  localparam int unsigned PIX_W  = 8;
  localparam int unsigned SIZE_W = 11;
  localparam int unsigned COL_W  = $clog2(MAX_WIDTH);
  localparam int unsigned ROW_W  = $clog2(MAX_HEIGHT + HALF);
  localparam int unsigned OROW_W = $clog2(MAX_HEIGHT);
  localparam int unsigned SPAN_W = ($clog2(MAX_WIDTH + 1) > SIZE_W) ?
                                   $clog2(MAX_WIDTH + 1) : SIZE_W;
  // Compare width: holds a size plus the half window without overflow.
  localparam int unsigned CNT_W  = SPAN_W + 1;

  // Register indexes of the configuration port.
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;

  // Mask weights, all powers of two, summing to 140.
  localparam int unsigned WGT_W = 5;
  localparam logic [WGT_W-1:0] WEIGHT [WIN][WIN] = '{
    '{5'd1, 5'd1, 5'd2, 5'd2,  5'd2, 5'd1, 5'd1},
    '{5'd1, 5'd2, 5'd2, 5'd4,  5'd2, 5'd2, 5'd1},
    '{5'd2, 5'd2, 5'd4, 5'd8,  5'd4, 5'd2, 5'd2},
    '{5'd2, 5'd4, 5'd8, 5'd16, 5'd8, 5'd4, 5'd2},
    '{5'd2, 5'd2, 5'd4, 5'd8,  5'd4, 5'd2, 5'd2},
    '{5'd1, 5'd2, 5'd2, 5'd4,  5'd2, 5'd2, 5'd1},
    '{5'd1, 5'd1, 5'd2, 5'd2,  5'd2, 5'd1, 5'd1}
  };

  // Row sum peaks at 44 * 255, the full sum at 140 * 255.
  localparam int unsigned RS_W  = 14;
  localparam int unsigned SUM_W = 16;

  // Sum / 140 = (sum >> 2) / 35 = ((sum >> 2) * 29960) >> 20, exact for sum <= 140 * 255.
  localparam int unsigned QUO_W       = SUM_W - 2;
  localparam int unsigned RECIP_W     = 15;
  localparam logic [RECIP_W-1:0] RECIP = 15'd29960;
  localparam int unsigned RECIP_SHIFT = 20;
  localparam int unsigned PROD_W      = QUO_W + RECIP_W;

endpackage

`default_nettype wire

// File: hdl/gaussian_smooth_7x7.sv
// 7x7 Gaussian smoothing of an 8-bit grayscale frame streamed in raster order.
//
// Input channel (in_valid_i / in_stall_o): one pixel per transfer. After the
// frame's last pixel, 3*width+3 further transfers (flush_i set, or any item)
// drain the last rows. A flush before the frame is complete is dropped.
// Output channel (out_valid_o / out_stall_i): one smoothed pixel per transfer,
// last_of_frame_o marks the frame's final pixel; counters then restart.
// Configuration (cfg_valid_i / cfg_ready_o, always ready): index 0 writes the
// width, index 1 the height; either write restarts the frame. Write only idle.
//
// Throughput is one item per cycle. The six line stores share one 48-bit
// wide memory at the column address: each item reads its column when taken
// and writes the shifted column back as it leaves stage 1. The item that
// completes a window (3 rows plus 3 pixels behind the input) carries it
// through the stage registers to the output register. When the receiver stalls
// with a result waiting, the whole pipeline holds and in_stall_o is raised.
// Reset restores 256x256 and clears counters; memory and window contents
// need no clearing, since every value left from before a frame lies outside
// it and is masked by position.
`default_nettype none

module gaussian_smooth_7x7
  import gs7_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire logic [PIX_W-1:0]     pixel_in_i,
  input  wire logic                 flush_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output logic [PIX_W-1:0]          smooth_pixel_o,
  output logic                      last_of_frame_o,
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [SIZE_W-1:0]    cfg_data_i
);

  typedef struct packed {
    logic             valid;
    logic             emit;
    logic             last;
    logic [PIX_W-1:0] pix;
    logic [COL_W-1:0] addr;
    logic [WIN-1:0]   rowok;
    logic [WIN-1:0]   colok;
  } s1_t;

  typedef struct packed {
    logic           valid;
    logic           last;
    logic [WIN-1:0] rowok;
    logic [WIN-1:0] colok;
  } s2_t;

  localparam int unsigned MEM_W = LINES * PIX_W;

  // Configuration and clamped sizes.
  logic [SIZE_W-1:0] width_q, height_q;
  logic [CNT_W-1:0]  w_eff, h_eff;
  logic              restart;

  // Position counters.
  logic [ROW_W-1:0]  in_row_q, in_row_d;
  logic [COL_W-1:0]  in_col_q, in_col_d;
  logic [OROW_W-1:0] out_row_q, out_row_d;
  logic [COL_W-1:0]  out_col_q, out_col_d;

  logic en, accept, take, in_frame, emit_now, last_now;
  logic [WIN-1:0] rowok_now, colok_now;

  s1_t s1_q;
  s2_t s2_q;
  logic [PIX_W-1:0] win_q [WIN][WIN];
  logic [PIX_W-1:0] col_new [WIN];

  logic             s3_valid_q, s3_last_q;
  logic [RS_W-1:0]  rs_q [WIN];
  logic [RS_W-1:0]  rs_d [WIN];
  logic             s4_valid_q, s4_last_q;
  logic [SUM_W-1:0] sum_q;
  logic [SUM_W-1:0] sum_d;
  logic             s5_valid_q, s5_last_q;
  logic [PROD_W-1:0] prod_q;

  logic             out_valid_q, out_last_q;
  logic [PIX_W-1:0] out_pix_q;

  logic [MEM_W-1:0] ram_rdata, ram_wdata;
  logic             ram_we;

  // Flow control: the pipeline moves unless a result waits on a stalled receiver.
  assign en          = !(out_valid_q && out_stall_i);
  assign in_stall_o  = !en;
  assign accept      = in_valid_i && en;
  assign cfg_ready_o = 1'b1;

  always_comb begin
    if (width_q < SIZE_W'(MIN_SIZE)) begin
      w_eff = CNT_W'(MIN_SIZE);
    end else if (CNT_W'(width_q) > CNT_W'(MAX_WIDTH)) begin
      w_eff = CNT_W'(MAX_WIDTH);
    end else begin
      w_eff = CNT_W'(width_q);
    end
    if (height_q < SIZE_W'(MIN_SIZE)) begin
      h_eff = CNT_W'(MIN_SIZE);
    end else if (CNT_W'(height_q) > CNT_W'(MAX_HEIGHT)) begin
      h_eff = CNT_W'(MAX_HEIGHT);
    end else begin
      h_eff = CNT_W'(height_q);
    end
  end

  assign restart = cfg_valid_i && (cfg_index_i == CFG_WIDTH || cfg_index_i == CFG_HEIGHT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= SIZE_W'(256);
      height_q <= SIZE_W'(256);
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_WIDTH:  width_q  <= cfg_data_i;
        CFG_HEIGHT: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Item classification at the input.
  assign in_frame = CNT_W'(in_row_q) < h_eff;
  assign take     = accept && !(flush_i && in_frame);
  assign emit_now = (in_row_q > ROW_W'(HALF)) ||
                    (in_row_q == ROW_W'(HALF) && in_col_q >= COL_W'(HALF));
  assign last_now = (CNT_W'(out_row_q) == h_eff - 1'b1) &&
                    (CNT_W'(out_col_q) == w_eff - 1'b1);

  // Window rows and columns that fall inside the frame.
  always_comb begin
    logic [CNT_W-1:0] r, c;
    for (int i = 0; i < WIN; i++) begin
      r = CNT_W'(out_row_q) + CNT_W'(i);
      c = CNT_W'(out_col_q) + CNT_W'(i);
      rowok_now[i] = (r >= CNT_W'(HALF)) && (r < h_eff + CNT_W'(HALF));
      colok_now[i] = (c >= CNT_W'(HALF)) && (c < w_eff + CNT_W'(HALF));
    end
  end

  always_comb begin
    in_row_d  = in_row_q;
    in_col_d  = in_col_q;
    out_row_d = out_row_q;
    out_col_d = out_col_q;
    if (restart) begin
      in_row_d  = '0;
      in_col_d  = '0;
      out_row_d = '0;
      out_col_d = '0;
    end else if (take) begin
      if (CNT_W'(in_col_q) + 1'b1 >= w_eff) begin
        in_col_d = '0;
        in_row_d = in_row_q + 1'b1;
      end else begin
        in_col_d = in_col_q + 1'b1;
      end
      if (emit_now) begin
        if (CNT_W'(out_col_q) + 1'b1 >= w_eff) begin
          out_col_d = '0;
          out_row_d = out_row_q + 1'b1;
        end else begin
          out_col_d = out_col_q + 1'b1;
        end
        if (last_now) begin
          in_row_d  = '0;
          in_col_d  = '0;
          out_row_d = '0;
          out_col_d = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_row_q  <= '0;
      in_col_q  <= '0;
      out_row_q <= '0;
      out_col_q <= '0;
    end else begin
      in_row_q  <= in_row_d;
      in_col_q  <= in_col_d;
      out_row_q <= out_row_d;
      out_col_q <= out_col_d;
    end
  end

  // Line stores: one memory word holds the six stored pixels of a column.
  // A column address comes back no sooner than three items later, so the
  // write-back always lands before the next read of the same word.
  gs7_ram #(
    .DATA_W (MEM_W),
    .DEPTH  (MAX_WIDTH)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (s1_q.addr),
    .wdata_i (ram_wdata),
    .re_i    (take),
    .raddr_i (in_col_q),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    for (int i = 0; i < LINES; i++) begin
      col_new[i] = ram_rdata[i*PIX_W +: PIX_W];
    end
    col_new[LINES] = s1_q.pix;
    for (int i = 0; i < LINES; i++) begin
      ram_wdata[i*PIX_W +: PIX_W] = col_new[i+1];
    end
  end

  assign ram_we = en && s1_q.valid;

  // Stage 1: the memory read is in flight.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q.valid <= 1'b0;
    end else begin
      if (en) begin
        s1_q.valid <= take;
      end
      if (take) begin
        s1_q.emit  <= emit_now;
        s1_q.last  <= last_now;
        s1_q.pix   <= in_frame ? pixel_in_i : '0;
        s1_q.addr  <= in_col_q;
        s1_q.rowok <= rowok_now;
        s1_q.colok <= colok_now;
      end
    end
  end

  // Stage 2: the window takes the new column on the right.
  always_ff @(posedge clk_i) begin
    if (ram_we) begin
      for (int i = 0; i < WIN; i++) begin
        for (int k = 0; k < WIN - 1; k++) begin
          win_q[i][k] <= win_q[i][k+1];
        end
        win_q[i][WIN-1] <= col_new[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_q.valid <= 1'b0;
    end else if (en) begin
      s2_q.valid <= s1_q.valid && s1_q.emit;
      s2_q.last  <= s1_q.last;
      s2_q.rowok <= s1_q.rowok;
      s2_q.colok <= s1_q.colok;
    end
  end

  // Stage 3: weighted row sums with positions outside the frame masked.
  always_comb begin
    for (int i = 0; i < WIN; i++) begin
      rs_d[i] = '0;
      for (int k = 0; k < WIN; k++) begin
        if (s2_q.rowok[i] && s2_q.colok[k]) begin
          rs_d[i] = rs_d[i] + RS_W'(win_q[i][k]) * RS_W'(WEIGHT[i][k]);
        end
      end
    end
  end

  // Stage 4: the window total.
  always_comb begin
    sum_d = '0;
    for (int i = 0; i < WIN; i++) begin
      sum_d = sum_d + SUM_W'(rs_q[i]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q  <= 1'b0;
      s4_valid_q  <= 1'b0;
      s5_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      s3_valid_q  <= s2_q.valid;
      s4_valid_q  <= s3_valid_q;
      s5_valid_q  <= s4_valid_q;
      out_valid_q <= s5_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      rs_q       <= rs_d;
      s3_last_q  <= s2_q.last;
      sum_q      <= sum_d;
      s4_last_q  <= s3_last_q;
      // Stage 5: divide by 140 through the reciprocal product.
      prod_q     <= PROD_W'(sum_q[SUM_W-1:2]) * PROD_W'(RECIP);
      s5_last_q  <= s4_last_q;
      out_pix_q  <= prod_q[RECIP_SHIFT +: PIX_W];
      out_last_q <= s5_last_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign smooth_pixel_o  = out_pix_q;
  assign last_of_frame_o = out_last_q;

  // The input column counter stays inside the row.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    CNT_W'(in_col_q) < w_eff)
    else $error("input column beyond frame width");

  // The output column counter stays inside the row.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    CNT_W'(out_col_q) < w_eff)
    else $error("output column beyond frame width");

  // The frame's final output restarts every position counter.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && emit_now && last_now) |=>
      (in_row_q == '0 && in_col_q == '0 && out_row_q == '0 && out_col_q == '0))
    else $error("counters not restarted after frame end");

  // A write-back never meets a read of the same column in one cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_we && take) |-> (s1_q.addr != in_col_q))
    else $error("line store read and write collide");

endmodule

`default_nettype wire

// File: hdl/gs7_ram.sv
`default_nettype none

module gs7_ram #(
  parameter int unsigned DATA_W = 8,
  parameter int unsigned DEPTH  = 16
) (
  input  wire logic                             clk_i,
  input  wire logic                             we_i,
  input  wire logic [$clog2(DEPTH)-1:0]         waddr_i,
  input  wire logic [DATA_W-1:0]                wdata_i,
  input  wire logic                             re_i,
  input  wire logic [$clog2(DEPTH)-1:0]         raddr_i,
  output logic [DATA_W-1:0]                     rdata_o
);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: verif/tb_gaussian_smooth_7x7.sv
`timescale 1ns / 100ps

module tb_gaussian_smooth_7x7;
  import gs7_pkg::*;

  localparam int unsigned ITEMS_TARGET = 500;
  localparam int unsigned PIPE_SLACK   = 12;
  localparam int unsigned STALL_LIMIT  = 2000;
  localparam int unsigned MASK_SUM     = 140;
  localparam int unsigned REPORT_MAX   = 20;
  localparam int unsigned REG_TOP      = 2**SIZE_W - 1;

  // Indexes past the two size registers; writes there must not restart the frame.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

  localparam int unsigned MASK [WIN][WIN] = '{
    '{1, 1, 2, 2,  2, 1, 1},
    '{1, 2, 2, 4,  2, 2, 1},
    '{2, 2, 4, 8,  4, 2, 2},
    '{2, 4, 8, 16, 8, 4, 2},
    '{2, 2, 4, 8,  4, 2, 2},
    '{1, 2, 2, 4,  2, 2, 1},
    '{1, 1, 2, 2,  2, 1, 1}
  };

  typedef struct packed {
    logic [PIX_W-1:0] pix;
    logic             last;
  } smooth_t;

  typedef enum logic {STEP_ITEM, STEP_REG} step_e;
  typedef enum {FILL_NOISE, FILL_BINARY, FILL_FLAT} fill_e;

  typedef struct packed {
    step_e                kind;
    logic [15:0]          reps;
    logic [CFG_IDX_W-1:0] idx;
    logic [SIZE_W-1:0]    data;
    logic                 flush;
    logic                 typed;
    logic                 typed_emit;
    smooth_t              typed_res;
  } plan_row_t;

  // Opening sequence: items at the reset size, clamped register values, an early
  // flush, then a frame that opens with zero pixels, whose first output must be zero.
  localparam plan_row_t PLAN [9] = '{
    '{STEP_ITEM, 16'd1,  CFG_WIDTH,  11'd0,   1'b1, 1'b1, 1'b0, '{8'd0, 1'b0}},
    '{STEP_ITEM, 16'd1,  CFG_WIDTH,  11'd255, 1'b0, 1'b1, 1'b0, '{8'd0, 1'b0}},
    '{STEP_ITEM, 16'd1,  CFG_WIDTH,  11'd0,   1'b0, 1'b1, 1'b0, '{8'd0, 1'b0}},
    '{STEP_REG,  16'd1,  CFG_WIDTH,  11'd3,   1'b0, 1'b0, 1'b0, '{8'd0, 1'b0}},
    '{STEP_REG,  16'd1,  CFG_HEIGHT, 11'd0,   1'b0, 1'b0, 1'b0, '{8'd0, 1'b0}},
    '{STEP_ITEM, 16'd1,  CFG_WIDTH,  11'd255, 1'b1, 1'b1, 1'b0, '{8'd0, 1'b0}},
    '{STEP_ITEM, 16'd24, CFG_WIDTH,  11'd0,   1'b0, 1'b1, 1'b0, '{8'd0, 1'b0}},
    '{STEP_ITEM, 16'd1,  CFG_WIDTH,  11'd0,   1'b0, 1'b1, 1'b1, '{8'd0, 1'b0}},
    '{STEP_ITEM, 16'd2,  CFG_WIDTH,  11'd255, 1'b0, 1'b0, 1'b0, '{8'd0, 1'b0}}
  };

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic [PIX_W-1:0]     pixel_in = '0;
  logic                 flush_in = 1'b0;
  logic                 out_stall = 1'b0;
  logic                 cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_WIDTH;
  logic [SIZE_W-1:0]    cfg_data = '0;
  logic                 in_stall;
  logic                 out_valid;
  logic [PIX_W-1:0]     smooth_pixel;
  logic                 last_of_frame;
  logic                 cfg_ready;

  // Predicted block state.
  logic [PIX_W-1:0]  line_mem [LINES][MAX_WIDTH];
  logic [PIX_W-1:0]  win [WIN][WIN];
  int unsigned       row_in, col_in, row_out, col_out;
  logic [SIZE_W-1:0] reg_width, reg_height;
  smooth_t           smoothed_q [$];

  bit          quiet = 1'b0;
  int unsigned stall_left = 0;
  int unsigned idle_cycles = 0;
  int unsigned errors = 0;
  int unsigned n_items = 0;
  int unsigned n_results = 0;
  int unsigned n_frame_ends = 0;
  int unsigned n_writes = 0;

  gaussian_smooth_7x7 DUT (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .pixel_in_i      (pixel_in),
    .flush_i         (flush_in),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .smooth_pixel_o  (smooth_pixel),
    .last_of_frame_o (last_of_frame),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data)
  );

  always #10 clk = ~clk;

  function automatic int unsigned fit_size(input logic [SIZE_W-1:0] raw,
                                           input int unsigned hi);
    if (raw < MIN_SIZE) return MIN_SIZE;
    if (raw > hi) return hi;
    return raw;
  endfunction

  function automatic void restart_frame();
    row_in = 0;
    col_in = 0;
    row_out = 0;
    col_out = 0;
  endfunction

  // Advances the predicted state by one accepted item; returns 1 when it yields a pixel.
  function automatic bit smooth_step(input logic [PIX_W-1:0] pix, input logic fl,
                                     output smooth_t res);
    int unsigned cols, rows, sum;
    logic [PIX_W-1:0] column [WIN];
    bit in_frame, emit;
    int r, c, i, k;
    cols = fit_size(reg_width, MAX_WIDTH);
    rows = fit_size(reg_height, MAX_HEIGHT);
    in_frame = row_in < rows;
    res = '0;
    if (fl && in_frame) return 0;

    for (i = 0; i < LINES; i++) column[i] = line_mem[i][col_in];
    column[LINES] = in_frame ? pix : '0;
    for (i = 0; i < LINES; i++) line_mem[i][col_in] = column[i+1];
    for (i = 0; i < WIN; i++) begin
      for (k = 0; k < WIN - 1; k++) win[i][k] = win[i][k+1];
      win[i][WIN-1] = column[i];
    end

    emit = row_in > HALF || (row_in == HALF && col_in >= HALF);
    col_in++;
    if (col_in >= cols) begin
      col_in = 0;
      row_in++;
    end
    if (!emit) return 0;

    // Window positions outside the frame contribute nothing.
    sum = 0;
    for (i = 0; i < WIN; i++) begin
      r = int'(row_out) - int'(HALF) + i;
      if (r < 0 || r >= int'(rows)) continue;
      for (k = 0; k < WIN; k++) begin
        c = int'(col_out) - int'(HALF) + k;
        if (c < 0 || c >= int'(cols)) continue;
        sum += win[i][k] * MASK[i][k];
      end
    end
    res.pix = PIX_W'(sum / MASK_SUM);
    res.last = (row_out == rows - 1) && (col_out == cols - 1);
    col_out++;
    if (col_out >= cols) begin
      col_out = 0;
      row_out++;
    end
    if (res.last) restart_frame();
    return 1;
  endfunction

  task automatic push_item(input logic [PIX_W-1:0] pix, input logic fl, input logic typed,
                           input logic typed_emit, input smooth_t typed_res);
    smooth_t res;
    bit emit;
    cfg_valid <= 1'b0;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid <= 1'b1;
    pixel_in <= pix;
    flush_in <= fl;
    do @(negedge clk); while (in_stall !== 1'b0);
    @(posedge clk);
    emit = smooth_step(pix, fl, res);
    if (typed) begin
      emit = typed_emit;
      res = typed_res;
    end
    if (emit) smoothed_q.push_back(res);
    n_items++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SIZE_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(negedge clk); while (cfg_ready !== 1'b1);
    @(posedge clk);
    if (idx == CFG_WIDTH) begin
      reg_width = val;
      restart_frame();
    end else if (idx == CFG_HEIGHT) begin
      reg_height = val;
      restart_frame();
    end
    n_writes++;
  endtask

  // Holds the sender off until all predicted pixels are out and the pipeline is empty.
  task automatic settle();
    in_valid <= 1'b0;
    cfg_valid <= 1'b0;
    while (smoothed_q.size() != 0) @(posedge clk);
    repeat (PIPE_SLACK) @(posedge clk);
  endtask

  // Sends the first stop items of a frame: its pixels, some led by a dropped flush, then the drain items.
  task automatic stream_frame(input int unsigned pixels, input int unsigned stop);
    fill_e fill;
    logic [PIX_W-1:0] level, pix;
    int unsigned n;
    fill = fill_e'($urandom_range(0, 2));
    level = PIX_W'($urandom_range(0, 255));
    for (n = 0; n < stop; n++) begin
      if (n < pixels) begin
        if ($urandom_range(0, 15) == 0)
          push_item(PIX_W'($urandom_range(0, 255)), 1'b1, 1'b0, 1'b0, '0);
        case (fill)
          FILL_FLAT:   pix = level;
          FILL_BINARY: pix = $urandom_range(0, 1) ? 8'hFF : 8'h00;
          default:     pix = PIX_W'($urandom_range(0, 255));
        endcase
        push_item(pix, 1'b0, 1'b0, 1'b0, '0);
      end else begin
        // Past the last pixel every item drains, whatever its flush bit.
        push_item(PIX_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b0, 1'b0, '0);
      end
    end
  endtask

  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_stall <= (stall_left != 1);
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(1, 5);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Outputs are stable at the falling edge, so a transfer at the next rising edge is known here.
  always @(negedge clk) begin : check_out
    smooth_t want;
    if (rst_n && out_valid === 1'b1 && !out_stall) begin
      n_results++;
      if (smoothed_q.size() == 0) begin
        errors++;
        if (errors <= REPORT_MAX)
          $display("%0t: unexpected result, smooth_pixel %0d last_of_frame %0d",
                   $time, smooth_pixel, last_of_frame);
      end else begin
        want = smoothed_q.pop_front();
        if (want.last) n_frame_ends++;
        if (smooth_pixel !== want.pix) begin
          errors++;
          if (errors <= REPORT_MAX)
            $display("%0t: smooth_pixel expected %0d, actual %0d",
                     $time, want.pix, smooth_pixel);
        end
        if (last_of_frame !== want.last) begin
          errors++;
          if (errors <= REPORT_MAX)
            $display("%0t: last_of_frame expected %0d, actual %0d",
                     $time, want.last, last_of_frame);
        end
      end
    end
  end

  always @(negedge clk) begin
    if (!rst_n || (in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall) ||
        (cfg_valid && cfg_ready === 1'b1)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= STALL_LIMIT) begin
      $display("%0t: no transfer for %0d cycles, %0d results outstanding",
               $time, STALL_LIMIT, smoothed_q.size());
      $display("FAIL gaussian_smooth_7x7");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    int unsigned phase, frames, f, cols, rows, full, stop, small_items;
    logic [SIZE_W-1:0] raw_w, raw_h;
    bit wide, tall;

    reg_width = 11'd256;
    reg_height = 11'd256;
    foreach (line_mem[i, k]) line_mem[i][k] = '0;
    foreach (win[i, k]) win[i][k] = '0;
    restart_frame();

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    foreach (PLAN[r]) begin
      if (PLAN[r].kind == STEP_REG) begin
        settle();
        write_reg(PLAN[r].idx, PLAN[r].data);
      end else begin
        repeat (PLAN[r].reps)
          push_item(PLAN[r].data[PIX_W-1:0], PLAN[r].flush, PLAN[r].typed,
                    PLAN[r].typed_emit, PLAN[r].typed_res);
      end
    end

    // Mostly whole frames of small size; the opening items of one very wide and one
    // very tall frame early on.
    phase = 0;
    small_items = 0;
    while (phase < 4 || small_items < ITEMS_TARGET) begin
      wide = (phase == 1);
      tall = (phase == 3);
      quiet = small_items >= ITEMS_TARGET - ITEMS_TARGET / 5;
      settle();
      if (wide) begin
        raw_w = SIZE_W'($urandom_range(MAX_WIDTH, REG_TOP));
        raw_h = SIZE_W'($urandom_range(0, MIN_SIZE));
      end else if (tall) begin
        raw_w = SIZE_W'($urandom_range(0, MIN_SIZE));
        raw_h = SIZE_W'($urandom_range(MAX_HEIGHT, REG_TOP));
      end else begin
        raw_w = SIZE_W'(($urandom_range(0, 5) == 0) ? $urandom_range(0, MIN_SIZE - 1) :
                                                      $urandom_range(MIN_SIZE, 12));
        raw_h = SIZE_W'(($urandom_range(0, 5) == 0) ? $urandom_range(0, MIN_SIZE - 1) :
                                                      $urandom_range(MIN_SIZE, 10));
      end
      if ($urandom_range(0, 1)) begin
        write_reg(CFG_WIDTH, raw_w);
        write_reg(CFG_HEIGHT, raw_h);
      end else begin
        write_reg(CFG_HEIGHT, raw_h);
        write_reg(CFG_WIDTH, raw_w);
      end
      if ($urandom_range(0, 5) == 0)
        write_reg($urandom_range(0, 1) ? CFG_SPARE_LO : CFG_SPARE_HI,
                  SIZE_W'($urandom_range(0, REG_TOP)));

      cols = fit_size(reg_width, MAX_WIDTH);
      rows = fit_size(reg_height, MAX_HEIGHT);
      full = cols * rows + HALF * cols + HALF;
      frames = (wide || tall) ? 1 : $urandom_range(1, 2);
      for (f = 0; f < frames; f++) begin
        stop = full;
        // The large frames are only started; the next register write restarts them.
        if (wide || tall)
          stop = $urandom_range(30, 60);
        // Now and then the last frame is cut short; the next register write restarts it.
        else if (f == frames - 1 && $urandom_range(0, 4) == 0)
          stop = $urandom_range(1, full - 1);
        stream_frame(cols * rows, stop);
        small_items += stop;
      end
      phase++;
    end

    settle();
    $display("Run covered %0d input items over %0d phases and %0d register writes.",
             n_items, phase, n_writes);
    $display("It checked %0d smoothed pixels and %0d frame ends, size registers from 0 to %0d.",
             n_results, n_frame_ends, REG_TOP);
    if (errors == 0) begin
      $display("PASS gaussian_smooth_7x7");
    end else begin
      $display("FAIL gaussian_smooth_7x7");
    end
    $finish;
  end

endmodule

// File: filelist.f
hdl/gs7_pkg.sv
hdl/gs7_ram.sv
hdl/gaussian_smooth_7x7.sv
verif/tb_gaussian_smooth_7x7.sv
